[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ssi_pkg.sv]
// Types and widths for the segment intersection pipeline.
package ssi_pkg;

  // Coordinate width and derived widths
  localparam int COORD_WIDTH = 16;
  localparam int W   = COORD_WIDTH;
  localparam int DW  = W + 1;          // endpoint differences
  localparam int PRW = 2 * DW;         // signed cross products
  localparam int SW  = 2 * W + 3;      // den, alpha, beta signed
  localparam int UW  = 2 * W + 2;      // den, alpha magnitudes
  localparam int LH  = UW / 2;         // low half of alpha for split multiply
  localparam int HH  = UW - LH;        // high half of alpha
  localparam int NW  = W + UW;         // dividend |dA| * alpha
  localparam int DIV_LAT = W + 1;      // divider lane depth: a register per quotient bit plus rounding

  // Input transaction: two segments
  typedef struct packed {
    logic signed [W-1:0] a_start_x;
    logic signed [W-1:0] a_start_y;
    logic signed [W-1:0] a_end_x;
    logic signed [W-1:0] a_end_y;
    logic signed [W-1:0] b_start_x;
    logic signed [W-1:0] b_start_y;
    logic signed [W-1:0] b_end_x;
    logic signed [W-1:0] b_end_y;
  } pair_t;

  // Output transaction: hit flag and point
  typedef struct packed {
    logic                hit;
    logic signed [W-1:0] cross_x;
    logic signed [W-1:0] cross_y;
  } isect_t;

  // Front end to divider lanes
  typedef struct packed {
    logic                valid;
    logic                hit;
    logic [NW-1:0]       num_x;
    logic [NW-1:0]       num_y;
    logic [UW-1:0]       den;
    logic signed [W-1:0] start_x;
    logic signed [W-1:0] start_y;
    logic                neg_x;
    logic                neg_y;
  } front_t;

  // One divider lane result
  typedef struct packed {
    logic [W-1:0]        q;
    logic signed [W-1:0] start;
    logic                neg;
  } lane_t;

  // Last pipeline stage into the output buffer
  typedef struct packed {
    logic  valid;
    logic  hit;
    lane_t x;
    lane_t y;
  } fin_t;

endpackage

[hdl/ssi_front.sv]
// Front end: differences, cross products, sign fix, hit test and dividend.
module ssi_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  ssi_pkg::pair_t  pair,
  output ssi_pkg::front_t fo
);

  localparam int W   = ssi_pkg::W;
  localparam int DW  = ssi_pkg::DW;
  localparam int PRW = ssi_pkg::PRW;
  localparam int SW  = ssi_pkg::SW;
  localparam int UW  = ssi_pkg::UW;
  localparam int LH  = ssi_pkg::LH;
  localparam int HH  = ssi_pkg::HH;
  localparam int NW  = ssi_pkg::NW;

  function automatic logic signed [DW-1:0] diff(logic signed [W-1:0] a,
                                                logic signed [W-1:0] b);
    return $signed({a[W-1], a}) - $signed({b[W-1], b});
  endfunction

  // valid bits
  logic v1, v2, v3, v4, v5;

  // stage 1
  logic signed [DW-1:0] dax1, day1, dbx1, dby1, ox1, oy1;
  logic signed [W-1:0]  sx1, sy1;
  // stage 2
  logic signed [PRW-1:0] pd0, pd1, pa0, pa1, pb0, pb1;
  logic [W-1:0]          magx2, magy2;
  logic                  negx2, negy2;
  logic signed [W-1:0]   sx2, sy2;
  logic [DW-1:0]         ndax, nday;
  // stage 3
  logic signed [SW-1:0]  den3, al3, be3;
  logic [W-1:0]          magx3, magy3;
  logic                  negx3, negy3;
  logic signed [W-1:0]   sx3, sy3;
  // stage 4
  logic signed [SW-1:0]  den4, al4, be4;
  logic                  dz4;
  logic [W-1:0]          magx4, magy4;
  logic                  negx4, negy4;
  logic signed [W-1:0]   sx4, sy4;
  // stage 5
  logic                  hit5;
  logic [W+LH-1:0]       plx5, ply5;
  logic [W+HH-1:0]       phx5, phy5;
  logic [UW-1:0]         den5;
  logic                  negx5, negy5;
  logic signed [W-1:0]   sx5, sy5;

  // negated direction for magnitudes
  assign ndax = -dax1;
  assign nday = -day1;

  // valid chain and data stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      fo.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      fo.valid <= v5;
    end

    if (en) begin
      // stage 1: direction and offset vectors
      dax1 <= diff(pair.a_end_x, pair.a_start_x);
      day1 <= diff(pair.a_end_y, pair.a_start_y);
      dbx1 <= diff(pair.b_end_x, pair.b_start_x);
      dby1 <= diff(pair.b_end_y, pair.b_start_y);
      ox1  <= diff(pair.b_start_x, pair.a_start_x);
      oy1  <= diff(pair.b_start_y, pair.a_start_y);
      sx1  <= pair.a_start_x;
      sy1  <= pair.a_start_y;

      // stage 2: six cross products, |dA|
      pd0   <= dbx1 * day1;
      pd1   <= dax1 * dby1;
      pa0   <= oy1 * dbx1;
      pa1   <= ox1 * dby1;
      pb0   <= oy1 * dax1;
      pb1   <= ox1 * day1;
      negx2 <= dax1[DW-1];
      negy2 <= day1[DW-1];
      magx2 <= dax1[DW-1] ? ndax[W-1:0] : dax1[W-1:0];
      magy2 <= day1[DW-1] ? nday[W-1:0] : day1[W-1:0];
      sx2   <= sx1;
      sy2   <= sy1;

      // stage 3: den, alpha, beta
      den3  <= $signed({pd0[PRW-1], pd0}) - $signed({pd1[PRW-1], pd1});
      al3   <= $signed({pa0[PRW-1], pa0}) - $signed({pa1[PRW-1], pa1});
      be3   <= $signed({pb0[PRW-1], pb0}) - $signed({pb1[PRW-1], pb1});
      magx3 <= magx2;
      magy3 <= magy2;
      negx3 <= negx2;
      negy3 <= negy2;
      sx3   <= sx2;
      sy3   <= sy2;

      // stage 4: make all three sign-consistent with den
      den4  <= den3[SW-1] ? -den3 : den3;
      al4   <= den3[SW-1] ? -al3 : al3;
      be4   <= den3[SW-1] ? -be3 : be3;
      dz4   <= (den3 == '0);
      magx4 <= magx3;
      magy4 <= magy3;
      negx4 <= negx3;
      negy4 <= negy3;
      sx4   <= sx3;
      sy4   <= sy3;

      // stage 5: range test, split partial products
      hit5  <= !dz4 && !al4[SW-1] && (al4 <= den4) && !be4[SW-1] && (be4 <= den4);
      plx5  <= magx4 * al4[LH-1:0];
      ply5  <= magy4 * al4[LH-1:0];
      phx5  <= magx4 * al4[UW-1:LH];
      phy5  <= magy4 * al4[UW-1:LH];
      den5  <= den4[UW-1:0];
      negx5 <= negx4;
      negy5 <= negy4;
      sx5   <= sx4;
      sy5   <= sy4;

      // stage 6: assemble dividends
      fo.hit     <= hit5;
      fo.num_x   <= {{(NW-W-LH){1'b0}}, plx5} + ({phx5, {LH{1'b0}}});
      fo.num_y   <= {{(NW-W-LH){1'b0}}, ply5} + ({phy5, {LH{1'b0}}});
      fo.den     <= den5;
      fo.start_x <= sx5;
      fo.start_y <= sy5;
      fo.neg_x   <= negx5;
      fo.neg_y   <= negy5;
    end
  end

endmodule

[hdl/ssi_div.sv]
// Divider lane: one restoring quotient bit per stage, then round half up.
module ssi_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic [ssi_pkg::NW-1:0]           num,
  input  logic [ssi_pkg::UW-1:0]           den,
  input  logic signed [ssi_pkg::W-1:0]     start,
  input  logic                             neg,
  output ssi_pkg::lane_t                   lane
);

  localparam int W  = ssi_pkg::W;
  localparam int UW = ssi_pkg::UW;
  localparam int NW = ssi_pkg::NW;

  typedef struct packed {
    logic [NW-1:0]       rem;
    logic [UW-1:0]       den;
    logic [W-1:0]        q;
    logic signed [W-1:0] start;
    logic                neg;
  } st_t;

  st_t st0;
  st_t st_r [W];
  st_t last;
  logic up;

  assign st0 = '{rem: num, den: den, q: '0, start: start, neg: neg};

  // one quotient bit per stage, MSB first
  for (genvar k = 0; k < W; k++) begin : g_stage
    localparam int SH = W - 1 - k;
    st_t cur, nxt;
    logic [NW-1:0] dsh;
    logic ge;

    if (k == 0) begin : g_first
      assign cur = st0;
    end else begin : g_rest
      assign cur = st_r[k-1];
    end

    assign dsh = {{(NW-UW){1'b0}}, cur.den} << SH;
    assign ge  = (cur.rem >= dsh);

    always_comb begin
      nxt = cur;
      if (ge) begin
        nxt.rem = cur.rem - dsh;
      end
      nxt.q[SH] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= nxt;
      end
    end
  end

  // round to nearest, ties up
  assign last = st_r[W-1];
  assign up   = ({last.rem[UW-1:0], 1'b0} >= {1'b0, last.den});

  always_ff @(posedge clk) begin
    if (en) begin
      lane.q     <= last.q + {{(W-1){1'b0}}, up};
      lane.start <= last.start;
      lane.neg   <= last.neg;
    end
  end

endmodule

[hdl/ssi_out.sv]
// Output stage: final add, output register and one-entry skid buffer.
module ssi_out (
  input  logic                  clk,
  input  logic                  rst,
  input  ssi_pkg::fin_t         fin,
  input  logic                  stall,
  output logic                  valid,
  output ssi_pkg::isect_t       isect,
  output logic                  skid_full
);

  localparam int W = ssi_pkg::W;

  ssi_pkg::isect_t res;
  ssi_pkg::isect_t skid;
  ssi_pkg::isect_t isect_next, skid_next;
  logic            valid_next, skid_full_next;
  logic            take;
  logic [W-1:0]    px, py;

  // point = start +/- rounded quotient
  assign px = fin.x.neg ? (fin.x.start - fin.x.q) : (fin.x.start + fin.x.q);
  assign py = fin.y.neg ? (fin.y.start - fin.y.q) : (fin.y.start + fin.y.q);

  always_comb begin
    res.hit     = fin.hit;
    res.cross_x = fin.hit ? $signed(px) : '0;
    res.cross_y = fin.hit ? $signed(py) : '0;
  end

  assign take = valid && !stall;

  // output / skid steering
  always_comb begin
    isect_next     = isect;
    skid_next      = skid;
    valid_next     = valid;
    skid_full_next = skid_full;
    if (skid_full) begin
      if (take) begin
        isect_next     = skid;
        skid_full_next = 1'b0;
      end
    end else if (fin.valid) begin
      if (!valid || take) begin
        isect_next = res;
        valid_next = 1'b1;
      end else begin
        skid_next      = res;
        skid_full_next = 1'b1;
      end
    end else if (take) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      skid_full <= 1'b0;
    end else begin
      valid     <= valid_next;
      skid_full <= skid_full_next;
    end
  end

  always_ff @(posedge clk) begin
    isect <= isect_next;
    skid  <= skid_next;
  end

endmodule

[hdl/segment_segment_intersection.sv]
// Top level of the pipelined 2-D segment intersection block.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------
//   pair     | pair_valid / pair_stall    | two segments, 8 coordinates
//   isect    | isect_valid / isect_stall  | hit, cross_x, cross_y
//
// One transaction per cycle sustained unless stalled; 6 front-end stages,
// one divider stage per quotient bit plus rounding, and the output
// register. The two coordinate dividers run as parallel lanes.
// Reset clears the valid bits and the skid buffer only.
// pair_stall is registered: it rises as a held result fills the skid
// entry, and the whole pipeline freezes until the result is taken.
module segment_segment_intersection (
  input  logic             clk,
  input  logic             rst,
  input  logic             pair_valid,
  output logic             pair_stall,
  input  ssi_pkg::pair_t   pair,
  output logic             isect_valid,
  input  logic             isect_stall,
  output ssi_pkg::isect_t  isect
);

  localparam int DL = ssi_pkg::DIV_LAT;

  ssi_pkg::front_t fo;
  ssi_pkg::lane_t  lane_x, lane_y;
  ssi_pkg::fin_t   fin;
  logic            adv;
  logic            skid_full;
  logic [DL-1:0]   vld_r;
  logic [DL-1:0]   hit_r;

  // pipeline moves whenever the skid entry is free
  assign adv        = !skid_full;
  assign pair_stall = skid_full;

  ssi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (pair_valid),
    .pair     (pair),
    .fo       (fo)
  );

  ssi_div u_div_x (
    .clk   (clk),
    .en    (adv),
    .num   (fo.num_x),
    .den   (fo.den),
    .start (fo.start_x),
    .neg   (fo.neg_x),
    .lane  (lane_x)
  );

  ssi_div u_div_y (
    .clk   (clk),
    .en    (adv),
    .num   (fo.num_y),
    .den   (fo.den),
    .start (fo.start_y),
    .neg   (fo.neg_y),
    .lane  (lane_y)
  );

  // valid and hit ride alongside the divider lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DL-2:0], fo.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r <= {hit_r[DL-2:0], fo.hit};
    end
  end

  always_comb begin
    fin.valid = vld_r[DL-1];
    fin.hit   = hit_r[DL-1];
    fin.x     = lane_x;
    fin.y     = lane_y;
  end

  ssi_out u_out (
    .clk       (clk),
    .rst       (rst),
    .fin       (fin),
    .stall     (isect_stall),
    .valid     (isect_valid),
    .isect     (isect),
    .skid_full (skid_full)
  );

endmodule

[hdl/ssi_check.sv]
// Port-level checker for the segment intersection block, with its bind.
`include "assert_macros.svh"

module ssi_check (
  input logic            clk,
  input logic            rst,
  input logic            pair_stall,
  input logic            isect_valid,
  input logic            isect_stall,
  input ssi_pkg::isect_t isect
);

  // held result stays valid
  `ASSERT_NEXT(a_hold_valid, clk, rst, isect_valid && isect_stall, isect_valid, "result dropped while stalled")

  // held result keeps its payload
  `ASSERT_NEXT(a_hold_data, clk, rst, isect_valid && isect_stall, $stable(isect), "result changed while stalled")

  // a miss reports the origin
  `ASSERT_IMP(a_miss_zero, clk, rst, isect_valid && !isect.hit, isect.cross_x == 0 && isect.cross_y == 0, "miss with nonzero point")

  // input back-pressure only follows a stalled result
  `ASSERT_IMP(a_stall_cause, clk, rst, pair_stall, $past(isect_valid && isect_stall), "input stalled without output stall")

endmodule

bind segment_segment_intersection ssi_check u_ssi_check (
  .clk         (clk),
  .rst         (rst),
  .pair_stall  (pair_stall),
  .isect_valid (isect_valid),
  .isect_stall (isect_stall),
  .isect       (isect)
);

[bench/tb_segment_segment_intersection.sv]
// Self-checking testbench for the segment_segment_intersection pipeline.
module tb_segment_segment_intersection;

  localparam int W            = ssi_pkg::W;
  localparam int LATENCY      = W + 8;
  localparam int TAIL_CYCLES  = 2 * LATENCY + 8;
  localparam int HOLD_LEN     = 300;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_PRINTS   = 40;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             pair_valid = 1'b0;
  logic             pair_stall;
  ssi_pkg::pair_t   pair = '0;
  logic             isect_valid;
  logic             isect_stall = 1'b0;
  ssi_pkg::isect_t  isect;

  // Pending segment pairs and predicted intersection points
  ssi_pkg::pair_t   pending_pairs[$];
  ssi_pkg::isect_t  expected_points[$];

  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;
  logic    hold_kick = 1'b0;
  int      hold_left;
  int      cycles = 0;
  int      n_errors = 0;
  int      n_pairs = 0;
  int      n_results = 0;
  int      n_hits = 0;
  int      n_in_stalled = 0;
  ssi_pkg::isect_t  want_pt;

  segment_segment_intersection u_dut (
    .clk         (clk),
    .rst         (rst),
    .pair_valid  (pair_valid),
    .pair_stall  (pair_stall),
    .pair        (pair),
    .isect_valid (isect_valid),
    .isect_stall (isect_stall),
    .isect       (isect)
  );

  always #5 clk = ~clk;

  // Move from segment A's start toward its end by num/den of its length,
  // rounding the magnitude half up so ties go away from zero.
  function automatic logic [W-1:0] step_along(longint start, longint delta, longint num,
                                               longint den);
    longint mag;
    longint prod;
    longint q;
    longint rem;
    mag  = (delta < 0) ? -delta : delta;
    prod = mag * num;
    q    = prod / den;
    rem  = prod % den;
    if (2 * rem >= den) q++;
    if (delta < 0) q = -q;
    return W'(start + q);
  endfunction

  // Expected crossing point of the two segments, exact integer arithmetic
  function automatic ssi_pkg::isect_t predict_crossing(ssi_pkg::pair_t p);
    longint dax, day, dbx, dby, ox, oy;
    longint den, alpha, beta;
    ssi_pkg::isect_t r;
    dax = longint'(p.a_end_x) - longint'(p.a_start_x);
    day = longint'(p.a_end_y) - longint'(p.a_start_y);
    dbx = longint'(p.b_end_x) - longint'(p.b_start_x);
    dby = longint'(p.b_end_y) - longint'(p.b_start_y);
    ox  = longint'(p.b_start_x) - longint'(p.a_start_x);
    oy  = longint'(p.b_start_y) - longint'(p.a_start_y);
    den = dbx * day - dax * dby;
    r   = '0;
    if (den != 0) begin
      alpha = oy * dbx - ox * dby;
      beta  = oy * dax - ox * day;
      if (den < 0) begin
        den   = -den;
        alpha = -alpha;
        beta  = -beta;
      end
      if (alpha >= 0 && alpha <= den && beta >= 0 && beta <= den) begin
        r.hit     = 1'b1;
        r.cross_x = step_along(longint'(p.a_start_x), dax, alpha, den);
        r.cross_y = step_along(longint'(p.a_start_y), day, alpha, den);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (n_errors < MAX_PRINTS)
      $display("MISMATCH cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    n_errors++;
  endtask

  task automatic add_pair(int ax0, int ay0, int ax1, int ay1,
                          int bx0, int by0, int bx1, int by1);
    ssi_pkg::pair_t p;
    p.a_start_x = W'(ax0);
    p.a_start_y = W'(ay0);
    p.a_end_x   = W'(ax1);
    p.a_end_y   = W'(ay1);
    p.b_start_x = W'(bx0);
    p.b_start_y = W'(by0);
    p.b_end_x   = W'(bx1);
    p.b_end_y   = W'(by1);
    pending_pairs.push_back(p);
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(0, 4))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  function automatic int full_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int near(int base, int spread);
    return base + int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  // Random pairs: noise, close clusters, parallels, shared ends and extremes
  task automatic queue_random_pairs(int count);
    int kind, bx, by, dx, dy, k, m, ax0, ay0, ax1, ay1, sx, sy;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      bx   = int'($urandom_range(0, 60000)) - 30000;
      by   = int'($urandom_range(0, 60000)) - 30000;
      case (kind)
        0, 1, 2, 3: begin
          add_pair(full_coord(), full_coord(), full_coord(), full_coord(),
                   full_coord(), full_coord(), full_coord(), full_coord());
        end
        4, 5, 6: begin
          add_pair(near(bx, 8), near(by, 8), near(bx, 8), near(by, 8),
                   near(bx, 8), near(by, 8), near(bx, 8), near(by, 8));
        end
        7: begin
          // parallel or collinear, sometimes degenerate
          dx  = near(0, 8);
          dy  = near(0, 8);
          k   = near(0, 2);
          ax0 = near(bx, 20);
          ay0 = near(by, 20);
          if ($urandom_range(0, 1) == 1) begin
            m  = near(0, 3);
            sx = ax0 + m * dx;
            sy = ay0 + m * dy;
          end else begin
            sx = near(bx, 20);
            sy = near(by, 20);
          end
          add_pair(ax0, ay0, ax0 + dx, ay0 + dy, sx, sy, sx + k * dx, sy + k * dy);
        end
        8: begin
          // B starts or ends on one of A's endpoints
          ax0 = near(bx, 50);
          ay0 = near(by, 50);
          ax1 = near(bx, 50);
          ay1 = near(by, 50);
          sx  = ($urandom_range(0, 1) == 1) ? ax1 : ax0;
          sy  = (sx == ax1) ? ay1 : ay0;
          if ($urandom_range(0, 1) == 1)
            add_pair(ax0, ay0, ax1, ay1, sx, sy, near(bx, 50), near(by, 50));
          else
            add_pair(ax0, ay0, ax1, ay1, near(bx, 50), near(by, 50), sx, sy);
        end
        default: begin
          add_pair(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                   pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
        end
      endcase
    end
  endtask

  task automatic queue_directed_pairs();
    // full-range diagonals and axes crossing near the origin, both directions
    add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    add_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
    add_pair(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767);
    add_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
    // parallel, collinear overlap, zero-length A, zero-length B
    add_pair(0, 0, 10, 0, 0, 5, 10, 5);
    add_pair(0, 0, 10, 0, 5, 0, 15, 0);
    add_pair(3, 3, 3, 3, 0, 0, 6, 6);
    add_pair(0, 0, 4, 0, 2, 0, 2, 0);
    // touching at A start, at A end, at B start, at B end
    add_pair(0, 0, 10, 0, 0, -5, 0, 5);
    add_pair(0, 0, 10, 0, 10, -5, 10, 5);
    add_pair(0, 0, 10, 0, 4, 0, 4, 7);
    add_pair(0, 0, 10, 0, 4, 7, 4, 0);
    // misses past each end of A and of B
    add_pair(0, 0, 10, 0, 12, -5, 12, 5);
    add_pair(0, 0, 10, 0, -2, -5, -2, 5);
    add_pair(0, 0, 10, 0, 4, 1, 4, 8);
    add_pair(0, 0, 10, 0, 4, -8, 4, -1);
    // rounding ties with positive and negative direction
    add_pair(0, 0, 3, 0, 1, -1, 2, 1);
    add_pair(0, 0, -3, 0, -1, -1, -2, 1);
    // negative denominator by reversing B
    add_pair(0, 0, 10, 10, 10, 0, 0, 10);
    add_pair(0, 0, 10, 10, 0, 10, 10, 0);
    // all-minimum and all-maximum coordinates
    add_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    add_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
  endtask

  task automatic drain_all();
    while (pending_pairs.size() != 0 || pair_valid || expected_points.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Driver: offers pending pairs, holds each until it is taken
  always @(posedge clk) begin : driver
    logic took;
    logic next_valid;
    if (rst) begin
      pair_valid <= 1'b0;
    end else begin
      took       = pair_valid && !pair_stall;
      next_valid = pair_valid && !took;
      if (took) begin
        expected_points.push_back(predict_crossing(pair));
        n_pairs++;
      end
      if (pair_valid && pair_stall) n_in_stalled++;
      if (!next_valid && pending_pairs.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        pair       <= pending_pairs.pop_front();
        next_valid = 1'b1;
      end
      pair_valid <= next_valid;
    end
  end

  // Long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (rst)
      hold_left <= 0;
    else if (hold_kick && hold_left == 0)
      hold_left <= HOLD_LEN;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  // Receiver stall
  always @(posedge clk) begin
    if (rst)
      isect_stall <= 1'b0;
    else
      isect_stall <= (hold_left > 1) || ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Monitor: compare each taken result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && isect_valid && !isect_stall) begin
      n_results++;
      if (expected_points.size() == 0) begin
        report_mismatch("result with nothing expected, hit", int'(isect.hit), 0);
      end else begin
        want_pt = expected_points.pop_front();
        if (want_pt.hit) n_hits++;
        if (isect.hit !== want_pt.hit)
          report_mismatch("hit", int'(isect.hit), int'(want_pt.hit));
        if (isect.cross_x !== want_pt.cross_x)
          report_mismatch("cross_x", int'(isect.cross_x), int'(want_pt.cross_x));
        if (isect.cross_y !== want_pt.cross_y)
          report_mismatch("cross_y", int'(isect.cross_y), int'(want_pt.cross_y));
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_points.size());
      $display("segment_segment_intersection verification failed");
      $finish;
    end
  end

  // Stimulus phases
  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    queue_directed_pairs();
    drain_all();

    // no idling, with a long receiver hold-off to back up the pipeline
    hold_kick = 1'b1;
    queue_random_pairs(100);
    @(negedge clk);
    hold_kick = 1'b0;
    drain_all();

    set_idling(86, 0);
    queue_random_pairs(100);
    drain_all();

    set_idling(0, 86);
    queue_random_pairs(100);
    drain_all();

    set_idling(11, 11);
    queue_random_pairs(100);
    drain_all();

    set_idling(0, 0);
    queue_random_pairs(100);
    drain_all();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_points.size() != 0)
      report_mismatch("predictions left over", 0, expected_points.size());

    $display("Checked %0d segment pairs (%0d crossing) over idle, stall and back-pressure",
             n_pairs, n_hits);
    $display("phases; input was held off for %0d cycles, %0d mismatches seen",
             n_in_stalled, n_errors);
    if (n_errors == 0)
      $display("segment_segment_intersection verification clean");
    else
      $display("segment_segment_intersection verification failed");
    $finish;
  end

endmodule

[segment_segment_intersection.f]
+incdir+hdl
hdl/ssi_pkg.sv
hdl/ssi_front.sv
hdl/ssi_div.sv
hdl/ssi_out.sv
hdl/segment_segment_intersection.sv
hdl/ssi_check.sv
bench/tb_segment_segment_intersection.sv
